// ===== rtl/lfu_pkg.sv =====
`timescale 1ns / 1ps

package lfu_pkg;

    localparam int ENTRIES_DEF = 16;

    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int USE_W   = 32;
    localparam int STAMP_W = 64;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
        logic [USE_W-1:0]   uses;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic req_valid;
        logic clr_last;
        logic scan_last;
        logic rsp_free;
    } status_t;

    typedef struct packed {
        logic req_ready;
        logic clr_wr;
        logic scan_init;
        logic scan_rd;
        logic commit;
    } ctrl_t;

endpackage

// ===== rtl/lfu_if.sv =====
`timescale 1ns / 1ps

interface lfu_req_if import lfu_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    action;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, action, key, value, input ready);
    modport sink (input valid, action, key, value, output ready);
endinterface

interface lfu_rsp_if import lfu_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;
    logic signed [KEY_W-1:0] evicted_key;

    modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
    modport sink (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

// ===== rtl/lfu_store.sv =====
`timescale 1ns / 1ps

module lfu_store import lfu_pkg::*; #(
    parameter int DEPTH = ENTRIES_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem_reg [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lfu_cmp.sv =====
`timescale 1ns / 1ps

module lfu_cmp import lfu_pkg::*; (
    input  entry_t             rd_entry,
    input  logic [KEY_W-1:0]   key,
    input  logic [USE_W-1:0]   best_uses,
    input  logic [STAMP_W-1:0] best_stamp,
    output logic               key_eq,
    output logic               rank_lt
);

    // fewer uses wins, older stamp breaks a tie
    always_comb
    begin
        key_eq  = (rd_entry.key == key);
        rank_lt = (rd_entry.uses < best_uses) ||
                  ((rd_entry.uses == best_uses) && (rd_entry.stamp < best_stamp));
    end

endmodule

// ===== rtl/lfu_ctrl.sv =====
`timescale 1ns / 1ps

module lfu_ctrl import lfu_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    output ctrl_t   ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (status.req_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (status.rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ctrl.clr_wr = 1'b1;
            end
            ST_IDLE:
            begin
                ctrl.req_ready = 1'b1;
                ctrl.scan_init = status.req_valid;
            end
            ST_SCAN:
            begin
                ctrl.scan_rd = 1'b1;
            end
            ST_TAIL:
            begin
                ctrl = '0;
            end
            ST_UPDATE:
            begin
                ctrl.commit = status.rsp_free;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

endmodule

// ===== rtl/lfu_cache_lru_tiebreak_core.sv =====
`timescale 1ns / 1ps

// least-frequently-used key/value cache, ties going to the oldest access
// req channel: one word is a get or a put (action, key, value)
// rsp channel: one word per request (hit, read_value, evicted, evicted_key)
// cfg_we / cfg_wdata: writes capacity_in_use, values above ENTRIES act as ENTRIES
// each request scans every entry through one memory read port, one entry a
// cycle, feeding a single key/rank comparator; the response is registered
// at the commit in the update state, after the scan and the tail state, and
// the next request is only taken back in the idle state after that commit
// after reset the entry store is cleared one entry a cycle, with req.ready
// low; the capacity register returns to 16
// a stalled rsp holds its word; a new request is still taken meanwhile and
// its scan runs, and it only waits at the update step for the rsp slot

module lfu_cache_lru_tiebreak_core import lfu_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    lfu_req_if.sink          req,
    lfu_rsp_if.source        rsp,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

    status_t status;
    ctrl_t   ctrl;

    logic [CAP_W-1:0]   cap_reg;
    logic [OCC_W-1:0]   occ_reg;
    logic [STAMP_W-1:0] clock_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               pend_reg;
    logic [IDX_W-1:0]   pend_idx_reg;

    logic               action_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VAL_W-1:0]   value_reg;

    logic               match_vld_reg;
    logic [IDX_W-1:0]   match_idx_reg;
    logic [VAL_W-1:0]   match_value_reg;
    logic [USE_W-1:0]   match_uses_reg;

    logic               best_vld_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [KEY_W-1:0]   best_key_reg;
    logic [USE_W-1:0]   best_uses_reg;
    logic [STAMP_W-1:0] best_stamp_reg;

    logic               free_vld_reg;
    logic [IDX_W-1:0]   free_idx_reg;

    logic               rsp_valid_reg;
    logic               hit_reg;
    logic [VAL_W-1:0]   read_value_reg;
    logic               evicted_reg;
    logic [KEY_W-1:0]   evicted_key_reg;

    entry_t             rd_entry;
    logic               key_eq;
    logic               rank_lt;

    // commit decision
    logic [CMP_W-1:0]   cap_ext;
    logic [CMP_W-1:0]   cap_eff;
    logic               full;
    logic               hit_next;
    logic [VAL_W-1:0]   read_value_next;
    logic               evicted_next;
    logic [KEY_W-1:0]   evicted_key_next;
    logic               wr_next;
    logic               occ_inc;
    logic [IDX_W-1:0]   slot_next;
    entry_t             wr_entry;
    logic [STAMP_W-1:0] stamp_next;
    logic [USE_W-1:0]   uses_inc;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    entry_t             mem_wdata;

    assign status.req_valid = req.valid;
    assign status.clr_last  = (idx_reg == IDX_LAST);
    assign status.scan_last = (idx_reg == IDX_LAST);
    assign status.rsp_free  = !rsp_valid_reg || rsp.ready;

    lfu_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    assign mem_we    = ctrl.clr_wr || (ctrl.commit && wr_next);
    assign mem_waddr = ctrl.clr_wr ? idx_reg : slot_next;
    assign mem_wdata = ctrl.clr_wr ? entry_t'('0) : wr_entry;

    lfu_store #(
        .DEPTH (ENTRIES),
        .AW    (IDX_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (ctrl.scan_rd),
        .raddr (idx_reg),
        .rdata (rd_entry)
    );

    lfu_cmp u_cmp (
        .rd_entry   (rd_entry),
        .key        (key_reg),
        .best_uses  (best_uses_reg),
        .best_stamp (best_stamp_reg),
        .key_eq     (key_eq),
        .rank_lt    (rank_lt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    // shared index for the clearing pass and the scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            pend_reg     <= 1'b0;
            pend_idx_reg <= '0;
        end
        else
        begin
            pend_reg     <= ctrl.scan_rd;
            pend_idx_reg <= idx_reg;
            if (ctrl.scan_init)
            begin
                idx_reg <= '0;
            end
            else if (ctrl.clr_wr || ctrl.scan_rd)
            begin
                idx_reg <= (idx_reg == IDX_LAST) ? '0 : idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.scan_init)
        begin
            action_reg <= req.action;
            key_reg    <= req.key;
            value_reg  <= req.value;
        end
    end

    // scan trackers, one entry per cycle behind the memory read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_vld_reg <= 1'b0;
            best_vld_reg  <= 1'b0;
            free_vld_reg  <= 1'b0;
        end
        else if (ctrl.scan_init)
        begin
            match_vld_reg <= 1'b0;
            best_vld_reg  <= 1'b0;
            free_vld_reg  <= 1'b0;
        end
        else if (pend_reg)
        begin
            if (rd_entry.valid)
            begin
                if (key_eq && !match_vld_reg)
                begin
                    match_vld_reg <= 1'b1;
                end
                if (!best_vld_reg || rank_lt)
                begin
                    best_vld_reg <= 1'b1;
                end
            end
            else if (!free_vld_reg)
            begin
                free_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            if (rd_entry.valid)
            begin
                if (key_eq && !match_vld_reg)
                begin
                    match_idx_reg   <= pend_idx_reg;
                    match_value_reg <= rd_entry.value;
                    match_uses_reg  <= rd_entry.uses;
                end
                if (!best_vld_reg || rank_lt)
                begin
                    best_idx_reg   <= pend_idx_reg;
                    best_key_reg   <= rd_entry.key;
                    best_uses_reg  <= rd_entry.uses;
                    best_stamp_reg <= rd_entry.stamp;
                end
            end
            else if (!free_vld_reg)
            begin
                free_idx_reg <= pend_idx_reg;
            end
        end
    end

    assign cap_ext    = CMP_W'(cap_reg);
    assign cap_eff    = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
    assign full       = (CMP_W'(occ_reg) >= cap_eff);
    assign stamp_next = clock_reg + STAMP_W'(1);
    // use count sticks at all ones
    assign uses_inc   = (match_uses_reg == '1) ? match_uses_reg
                                               : match_uses_reg + USE_W'(1);

    always_comb
    begin
        hit_next         = 1'b0;
        read_value_next  = '0;
        evicted_next     = 1'b0;
        evicted_key_next = '0;
        wr_next          = 1'b0;
        occ_inc          = 1'b0;
        slot_next        = match_idx_reg;
        wr_entry.valid   = 1'b1;
        wr_entry.key     = key_reg;
        wr_entry.value   = value_reg;
        wr_entry.uses    = USE_W'(1);
        wr_entry.stamp   = stamp_next;
        if (action_reg == ACT_GET)
        begin
            if (match_vld_reg)
            begin
                hit_next        = 1'b1;
                read_value_next = match_value_reg;
                wr_next         = 1'b1;
                wr_entry.value  = match_value_reg;
                wr_entry.uses   = uses_inc;
            end
            else
            begin
                read_value_next = MISS_VALUE;
            end
        end
        else if (cap_reg != '0)
        begin
            if (match_vld_reg)
            begin
                hit_next      = 1'b1;
                wr_next       = 1'b1;
                wr_entry.uses = uses_inc;
            end
            else if (full)
            begin
                evicted_next     = best_vld_reg;
                evicted_key_next = best_vld_reg ? best_key_reg : '0;
                wr_next          = best_vld_reg;
                slot_next        = best_idx_reg;
            end
            else
            begin
                wr_next   = free_vld_reg;
                occ_inc   = free_vld_reg;
                slot_next = free_idx_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= '0;
            clock_reg <= '0;
        end
        else if (ctrl.commit)
        begin
            if (occ_inc)
            begin
                occ_reg <= occ_reg + OCC_W'(1);
            end
            if (wr_next)
            begin
                clock_reg <= stamp_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (ctrl.commit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            hit_reg         <= hit_next;
            read_value_reg  <= read_value_next;
            evicted_reg     <= evicted_next;
            evicted_key_reg <= evicted_key_next;
        end
    end

    assign req.ready       = ctrl.req_ready;
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.hit         = hit_reg;
    assign rsp.read_value  = read_value_reg;
    assign rsp.evicted     = evicted_reg;
    assign rsp.evicted_key = evicted_key_reg;

endmodule
